// ===== sv/acs_pkg.sv =====
package acs_pkg;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic CFG_MATRIX_SIZE = 1'b0;
  localparam logic CFG_THRESHOLD   = 1'b1;

  localparam int SIZE_W     = 7;
  localparam int THRESH_W   = 32;
  localparam int CONTACT_W  = 32;
  localparam int INDEX_W    = 6;
  localparam int SCORE_W    = 16;
  localparam int QUOT_W     = 15;
  localparam int CFG_DATA_W = 32;

  localparam logic [SIZE_W-1:0]   SIZE_RESET   = 7'd64;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 32'd655;

  typedef struct packed {
    logic [1:0]           func;
    logic [INDEX_W-1:0]   row;
    logic [INDEX_W-1:0]   col;
    logic [CONTACT_W-1:0] contact;
  } in_item_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      score_computed;
    logic                      out_of_range;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_RDA,
    ST_RDB,
    ST_SUM,
    ST_DIV,
    ST_RESULT
  } acs_state_t;

endpackage

// ===== sv/acs_chan_if.sv =====
interface acs_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/acs_store.sv =====
module acs_store #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);
  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/acs_divider.sv =====
module acs_divider #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [VALUE_WIDTH-1:0]     dividend,
  input  logic [VALUE_WIDTH:0]       divisor,
  output logic [acs_pkg::QUOT_W-1:0] quotient,
  output logic                       done
);
  import acs_pkg::*;

  localparam int REM_W = VALUE_WIDTH + 1;
  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] den;
  logic [CNT_W-1:0] count;
  logic             busy;
  logic [REM_W:0]   shifted;
  logic             fits;

  assign shifted = {rem, 1'b0};
  assign fits    = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(QUOT_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= REM_W'(dividend);
      den      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= fits ? REM_W'(shifted - {1'b0, den}) : REM_W'(shifted);
      quotient <= {quotient[QUOT_W-2:0], fits};
    end
  end
endmodule

// ===== sv/arrowhead_contact_score.sv =====
// Channel  Dir  Beat         Fields
// in_ch    in   one item     func, row, col, contact
// out_ch   out  one result   score, score_computed, out_of_range
// cfg      in   one write    cfg_we, cfg_index, cfg_data
//
// Loads and clears never leave the idle state; the block is ready again at once.
// A read that forms a ratio goes through a row check, two reads of the contact
// memory, a sum, a division for 15 quotient bits and a result load. Other reads
// skip to the result load after the row check, or after a sum not above the threshold.
// Reset is synchronous; it clears the row flags and restores both registers.
// A finished read waits at its end until the output register is free.
module arrowhead_contact_score #(
  parameter int MAX_SIZE    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [acs_pkg::CFG_DATA_W-1:0] cfg_data,
  acs_chan_if.sink                      in_ch,
  acs_chan_if.source                    out_ch
);
  import acs_pkg::*;

  localparam int IDX_W  = $clog2(MAX_SIZE);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int CMP_W  = (VALUE_WIDTH + 1 > THRESH_W) ? VALUE_WIDTH + 1 : THRESH_W;

  acs_state_t state, state_next;

  logic [SIZE_W-1:0]      matrix_size;
  logic [THRESH_W-1:0]    contact_threshold;
  logic [MAX_SIZE-1:0]    row_valid;
  in_item_t               item;
  in_item_t               in_item;

  logic [VALUE_WIDTH-1:0] a_val;
  logic [VALUE_WIDTH-1:0] diff;
  logic [VALUE_WIDTH:0]   total;
  logic                   negative;
  logic                   above;
  logic                   computed;
  logic                   out_range;
  out_item_t              result;
  logic                   out_valid;

  logic                   accept;
  logic                   in_range_new;
  logic                   in_range;
  logic                   eligible;
  logic [INDEX_W-1:0]     idx_i;
  logic [INDEX_W-1:0]     idx_j;
  logic [INDEX_W-1:0]     idx_k;
  logic [VALUE_WIDTH-1:0] new_value;
  logic [VALUE_WIDTH-1:0] rdata;
  logic [ADDR_W-1:0]      raddr;
  logic                   store_we;
  logic                   div_start;
  logic                   div_done;
  logic [QUOT_W-1:0]      quotient;
  logic                   in_ready;
  logic                   result_load;
  logic                   out_free;
  logic [CMP_W-1:0]       sum_wide;
  logic [SCORE_W-1:0]     magnitude;

  assign in_item  = in_ch.data;
  assign accept   = in_ch.valid && in_ready;
  assign out_free = !out_valid || out_ch.ready;

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = result;

  assign new_value    = VALUE_WIDTH'(in_item.contact);
  assign in_range_new = (SIZE_W'(in_item.row) < matrix_size)
                        && (SIZE_W'(in_item.col) < matrix_size)
                        && (32'(in_item.row) < MAX_SIZE)
                        && (32'(in_item.col) < MAX_SIZE);
  assign store_we     = accept && (in_item.func == FUNC_LOAD) && in_range_new;

  assign in_range = (SIZE_W'(item.row) < matrix_size)
                    && (SIZE_W'(item.col) < matrix_size)
                    && (32'(item.row) < MAX_SIZE)
                    && (32'(item.col) < MAX_SIZE);
  assign idx_i    = (item.row < item.col) ? item.row : item.col;
  assign idx_j    = (item.row < item.col) ? item.col : item.row;
  assign idx_k    = INDEX_W'({idx_i, 1'b0} - {1'b0, idx_j});
  assign eligible = in_range && (idx_j > idx_i) && ({idx_i, 1'b0} > {1'b0, idx_j})
                    && row_valid[IDX_W'(idx_i)] && row_valid[IDX_W'(idx_j)];

  assign sum_wide  = CMP_W'(a_val) + CMP_W'(rdata);
  assign diff      = (a_val >= rdata) ? (a_val - rdata) : (rdata - a_val);
  assign total     = (VALUE_WIDTH + 1)'(sum_wide);
  assign above     = sum_wide > CMP_W'(contact_threshold);
  assign magnitude = {1'b0, quotient};

  acs_store #(
    .ADDR_W (ADDR_W),
    .DATA_W (VALUE_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr ({IDX_W'(in_item.row), IDX_W'(in_item.col)}),
    .wdata (new_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  acs_divider #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (diff),
    .divisor  (total),
    .quotient (quotient),
    .done     (div_done)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (in_item.func == FUNC_READ)) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_next = eligible ? ST_RDA : ST_RESULT;
      end
      ST_RDA: begin
        state_next = ST_RDB;
      end
      ST_RDB: begin
        state_next = ST_SUM;
      end
      ST_SUM: begin
        state_next = above ? ST_DIV : ST_RESULT;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    div_start   = 1'b0;
    result_load = 1'b0;
    raddr       = {IDX_W'(idx_i), IDX_W'(idx_k)};
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_RDA: begin
        raddr = {IDX_W'(idx_i), IDX_W'(idx_j)};
      end
      ST_SUM: begin
        div_start = above;
      end
      ST_RESULT: begin
        result_load = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      matrix_size       <= SIZE_RESET;
      contact_threshold <= THRESH_RESET;
      row_valid         <= '0;
      out_valid         <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MATRIX_SIZE: matrix_size       <= SIZE_W'(cfg_data);
          CFG_THRESHOLD:   contact_threshold <= THRESH_W'(cfg_data);
          default:         matrix_size       <= matrix_size;
        endcase
      end
      if (accept && (in_item.func == FUNC_CLEAR)) begin
        row_valid <= '0;
      end else if (store_we && (CMP_W'(new_value) > CMP_W'(contact_threshold))) begin
        row_valid[IDX_W'(in_item.row)] <= 1'b1;
      end
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_item;
    end
    if (state == ST_EVAL) begin
      out_range <= !in_range;
      computed  <= 1'b0;
    end
    if (state == ST_RDB) begin
      a_val <= rdata;
    end
    if (state == ST_SUM) begin
      negative <= a_val < rdata;
    end
    if ((state == ST_DIV) && div_done) begin
      computed <= 1'b1;
    end
    if (result_load) begin
      result.out_of_range   <= out_range;
      result.score_computed <= computed;
      if (!computed) begin
        result.score <= '0;
      end else if (negative) begin
        result.score <= $signed(SCORE_W'(0) - magnitude);
      end else begin
        result.score <= $signed(magnitude);
      end
    end
  end
endmodule
